[design/lrms_pkg.sv]
// Shared constants and types of the low-pass RMS level meter.
// Depends on nothing; every other file of the block imports it.
package lrms_pkg;

  localparam int SampleW = 16;
  localparam int CoefW = 16;
  localparam int GainW = 3;
  localparam int LevelW = 16;
  localparam int FiltW = 24;
  localparam int FiltFrac = 8;
  localparam int SqShift = 15;
  localparam int SqW = 32;
  localparam int RadW = SqW + 2;
  localparam int RootW = RadW / 2;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW = 16;
  localparam int QueueDepth = 4;
  localparam int MaxBufferSamples = 4096;

  localparam logic [CoefW-1:0] CoefReset = 16'd3932;
  localparam logic [GainW-1:0] GainReset = 3'd2;

  typedef enum logic [CfgIndexW-1:0] {
    REG_FILTER_COEF = 1'b0,
    REG_GAIN_SHIFT  = 1'b1
  } cfg_reg_e;

endpackage

[design/lrms_front.sv]
// Front part of the level meter: accepts samples, runs the one-pole filter, squares
// and accumulates, and queues one job per finished buffer. Imports lrms_pkg.
module lrms_front import lrms_pkg::*; #(
  parameter int MaxSamples = MaxBufferSamples,
  parameter int CntW = 13,
  parameter int SumW = 44,
  parameter int FreeW = 3
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                     end_of_buffer_i,
  input  logic [CoefW-1:0]         coef_i,
  input  logic [FreeW-1:0]         queue_free_i,
  output logic                     push_o,
  output logic [SumW-1:0]          push_sum_o,
  output logic [CntW-1:0]          push_cnt_o
);

  localparam int DiffW = FiltW + 1;
  localparam int ProdW = DiffW + CoefW + 1;
  localparam int StepW = ProdW - 16;
  localparam int NfW = StepW + 1;
  localparam logic signed [NfW-1:0] FMax = NfW'((1 << (FiltW - 1)) - 1);
  localparam logic signed [NfW-1:0] FMin = -NfW'(1 << (FiltW - 1));

  logic                     accept;
  logic signed [FiltW-1:0]  x;
  logic signed [DiffW-1:0]  diff;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  prod_rnd;
  logic signed [NfW-1:0]    nf;
  logic signed [FiltW-1:0]  f_d, f_q;
  logic [CntW-1:0]          cnt_d, cnt_q;
  logic                     counted;
  logic [CntW-1:0]          cnt_inc;

  logic                     s1_valid_q, s1_last_q, s1_counted_q;
  logic [CntW-1:0]          s1_cnt_q;
  logic                     s2_valid_q, s2_last_q, s2_counted_q;
  logic [CntW-1:0]          s2_cnt_q;
  logic [FiltW-1:0]         mag;
  logic [2*FiltW-1:0]       mag_sq;
  logic [SqW-1:0]           sq_q;
  logic [SumW-1:0]          sum_d, sum_q;
  logic [SumW-1:0]          sum_add;
  logic [1:0]               pending;

  assign pending = {1'b0, s1_valid_q & s1_last_q} + {1'b0, s2_valid_q & s2_last_q};
  assign in_ready_o = queue_free_i > FreeW'(pending);
  assign accept = in_valid_i & in_ready_o;

  assign x = {sample_i, {FiltFrac{1'b0}}};
  assign diff = DiffW'(x) - DiffW'(f_q);
  assign prod = $signed({1'b0, coef_i}) * diff;
  assign prod_rnd = prod + ProdW'(32768);
  assign nf = NfW'(f_q) + NfW'($signed(prod_rnd[ProdW-1:16]));

  always_comb begin
    if (nf > FMax) begin
      f_d = FMax[FiltW-1:0];
    end else if (nf < FMin) begin
      f_d = FMin[FiltW-1:0];
    end else begin
      f_d = nf[FiltW-1:0];
    end
  end

  assign counted = cnt_q < CntW'(MaxSamples);
  assign cnt_inc = cnt_q + CntW'(counted);
  assign cnt_d = end_of_buffer_i ? '0 : cnt_inc;

  assign mag = f_q[FiltW-1] ? (~f_q + 1'b1) : f_q;
  assign mag_sq = mag * mag;

  assign sum_add = sum_q + (s2_counted_q ? SumW'(sq_q) : '0);
  assign sum_d = s2_last_q ? '0 : sum_add;

  assign push_o = s2_valid_q & s2_last_q;
  assign push_sum_o = sum_add;
  assign push_cnt_o = s2_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q <= '0;
      cnt_q <= '0;
      sum_q <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (accept) begin
        f_q <= f_d;
        cnt_q <= cnt_d;
      end
      if (s2_valid_q) begin
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= end_of_buffer_i;
    s1_counted_q <= counted;
    s1_cnt_q <= cnt_inc;
    s2_last_q <= s1_last_q;
    s2_counted_q <= s1_counted_q;
    s2_cnt_q <= s1_cnt_q;
    sq_q <= mag_sq[SqShift +: SqW];
  end

endmodule

[design/lrms_fifo.sv]
// Short job queue between the front and back parts of the level meter.
// Imports lrms_pkg for consistency with the rest of the block.
module lrms_fifo import lrms_pkg::*; #(
  parameter int Width = 57,
  parameter int Depth = QueueDepth,
  parameter int FreeW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o,
  output logic [FreeW-1:0] free_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [FreeW-1:0] count_d, count_q;

  assign valid_o = count_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign free_o = FreeW'(Depth) - count_q;

  assign wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign count_d = count_q + FreeW'(push_i) - FreeW'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_d;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != FreeW'(Depth))
    else $error("job queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("job queue read while empty");

endmodule

[design/lrms_back.sv]
// Back part of the level meter: divides the sum by the count, takes the square root
// bit by bit, scales and saturates, and holds the level in the output register.
// Imports lrms_pkg.
module lrms_back import lrms_pkg::*; #(
  parameter int CntW = 13,
  parameter int SumW = 44
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  logic [SumW-1:0]   job_sum_i,
  input  logic [CntW-1:0]   job_cnt_i,
  output logic              job_pop_o,
  input  logic [GainW-1:0]  gain_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LevelW-1:0] level_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_e;

  localparam int StepW = $clog2(SumW);
  localparam int RemW = RootW + 2;
  localparam int WideW = RootW + (1 << GainW) - 1;

  back_state_e       state_d, state_q;
  logic [StepW-1:0]  step_d, step_q;
  logic [SumW-1:0]   dq_d, dq_q;
  logic [CntW-1:0]   div_rem_d, div_rem_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic [RadW-1:0]   rad_d, rad_q;
  logic [RemW-1:0]   sq_rem_d, sq_rem_q;
  logic [RootW-1:0]  root_d, root_q;
  logic [LevelW-1:0] level_d, level_q;
  logic              out_valid_d, out_valid_q;

  logic [CntW:0]     div_sh;
  logic              div_ge;
  logic [CntW:0]     div_diff;
  logic [SumW-1:0]   dq_shift;
  logic [RemW+1:0]   sq_r;
  logic [RemW+1:0]   sq_trial;
  logic              sq_ge;
  logic [RemW+1:0]   sq_diff;
  logic [WideW-1:0]  lvl_wide;
  logic [LevelW-1:0] lvl_sat;

  assign div_sh = {div_rem_q, dq_q[SumW-1]};
  assign div_ge = div_sh >= {1'b0, cnt_q};
  assign div_diff = div_sh - {1'b0, cnt_q};
  assign dq_shift = {dq_q[SumW-2:0], div_ge};

  assign sq_r = {sq_rem_q, rad_q[RadW-1 -: 2]};
  assign sq_trial = {{(RemW - RootW){1'b0}}, root_q, 2'b01};
  assign sq_ge = sq_r >= sq_trial;
  assign sq_diff = sq_r - sq_trial;

  assign lvl_wide = WideW'(root_q) << gain_i;
  assign lvl_sat = (|lvl_wide[WideW-1:LevelW]) ? '1 : lvl_wide[LevelW-1:0];

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    dq_d = dq_q;
    div_rem_d = div_rem_q;
    cnt_d = cnt_q;
    rad_d = rad_q;
    sq_rem_d = sq_rem_q;
    root_d = root_q;
    level_d = level_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    job_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          dq_d = job_sum_i;
          cnt_d = job_cnt_i;
          div_rem_d = '0;
          step_d = StepW'(SumW - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        dq_d = dq_shift;
        div_rem_d = div_ge ? div_diff[CntW-1:0] : div_sh[CntW-1:0];
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          rad_d = {1'b0, dq_shift[SqW-1:0], 1'b0};
          sq_rem_d = '0;
          root_d = '0;
          step_d = StepW'(RootW - 1);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rad_d = {rad_q[RadW-3:0], 2'b00};
        sq_rem_d = sq_ge ? sq_diff[RemW-1:0] : sq_r[RemW-1:0];
        root_d = {root_q[RootW-2:0], sq_ge};
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          level_d = (cnt_q == '0) ? '0 : lvl_sat;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
    div_rem_q <= div_rem_d;
    cnt_q <= cnt_d;
    rad_q <= rad_d;
    sq_rem_q <= sq_rem_d;
    root_q <= root_d;
    level_q <= level_d;
  end

  assign out_valid_o = out_valid_q;
  assign level_o = level_q;

  a_level_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("level presented without a finished computation");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> cnt_q != '0)
    else $error("division started with an empty sample count");

endmodule

[design/lowpass_rms_level_meter_top.sv]
// Top level of the low-pass RMS level meter: configuration registers, front part,
// job queue and back part. Imports lrms_pkg; instantiates lrms_front, lrms_fifo, lrms_back.
//
// Samples arrive on the input channel (sample_i, end_of_buffer_i with in_valid_i and
// in_ready_o), one item per cycle while the job queue has room. Each sample goes
// through the shared one-pole filter, is squared and summed; the item that carries
// end_of_buffer_i closes the buffer and produces one level on the output channel
// (level_o with out_valid_o and out_ready_i). Other items produce nothing.
// The front part takes a sample every cycle while the job queue has room; the item
// closing a buffer passes the s1 and s2 stage registers before it reaches the queue.
// The back part then fetches the job, runs the restoring division over every bit of
// the sum (44 at default size), takes the 17-bit square root and loads the output
// register. Short buffers can fill the four-entry queue faster than the back part
// empties it, and in_ready_o then drops until the back part takes a job.
// A stalled receiver holds the level in the output register while the back part goes
// on with the next job; once both are waiting the queue fills and input stalls.
// Reset clears the filter state, the sum and count, the queue, and sets the filter
// coefficient to 3932 and the gain shift to 2. Registers are written through cfg_we_i.
module lowpass_rms_level_meter_top import lrms_pkg::*; #(
  parameter int MAX_BUFFER_SAMPLES = MaxBufferSamples
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      end_of_buffer_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [LevelW-1:0]         level_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIndexW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  localparam int CntW = $clog2(MAX_BUFFER_SAMPLES + 1);
  localparam longint SumMax = longint'(MAX_BUFFER_SAMPLES) * (longint'(1) << (SqW - 1));
  localparam int SumW = $clog2(SumMax + 1);
  localparam int JobW = SumW + CntW;
  localparam int FreeW = $clog2(QueueDepth + 1);

  logic [CoefW-1:0] coef_q;
  logic [GainW-1:0] gain_q;

  logic             push;
  logic [SumW-1:0]  push_sum;
  logic [CntW-1:0]  push_cnt;
  logic             job_valid;
  logic             job_pop;
  logic [JobW-1:0]  job_data;
  logic [FreeW-1:0] queue_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= CoefReset;
      gain_q <= GainReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FILTER_COEF: coef_q <= cfg_data_i[CoefW-1:0];
        REG_GAIN_SHIFT:  gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  lrms_front #(
    .MaxSamples (MAX_BUFFER_SAMPLES),
    .CntW       (CntW),
    .SumW       (SumW),
    .FreeW      (FreeW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .end_of_buffer_i (end_of_buffer_i),
    .coef_i          (coef_q),
    .queue_free_i    (queue_free),
    .push_o          (push),
    .push_sum_o      (push_sum),
    .push_cnt_o      (push_cnt)
  );

  lrms_fifo #(
    .Width (JobW),
    .Depth (QueueDepth),
    .FreeW (FreeW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_sum, push_cnt}),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .rdata_o (job_data),
    .free_o  (queue_free)
  );

  lrms_back #(
    .CntW (CntW),
    .SumW (SumW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_sum_i   (job_data[JobW-1:CntW]),
    .job_cnt_i   (job_data[CntW-1:0]),
    .job_pop_o   (job_pop),
    .gain_i      (gain_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (level_o)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// Testbench for lowpass_rms_level_meter_top: drives sample buffers and register settings,
// predicts every level with its own filter and RMS model and checks each level in order.
// Depends on lrms_pkg and the RTL of the level meter.
module tb import lrms_pkg::*;;

  localparam int NumPhases = 9;
  localparam int PhaseItems = 130;
  localparam int SettleCycles = 100;
  localparam int HoldCycles = 600;
  localparam int IdleLimit = 5000;
  localparam longint FiltMax = (longint'(1) <<< (FiltW - 1)) - 1;
  localparam longint FiltMin = -(longint'(1) <<< (FiltW - 1));
  localparam logic signed [SampleW-1:0] SmpMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SmpMin = 16'sh8000;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SELDOM, RX_PERIODIC} rx_mode_e;
  typedef enum int {SMP_FULL, SMP_QUIET, SMP_EXTREME, SMP_HELD} smp_style_e;

  class level_scoreboard;
    bit [CoefW-1:0] coef;
    bit [GainW-1:0] gain;
    longint filt;
    longint unsigned sq_sum;
    int unsigned sq_count;
    bit [LevelW-1:0] levels_due[$];
    int errors;
    int samples;
    int levels_seen;
    int saturated;

    function new();
      coef = CoefReset;
      gain = GainReset;
      filt = 0;
      sq_sum = 0;
      sq_count = 0;
      errors = 0;
      samples = 0;
      levels_seen = 0;
      saturated = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_FILTER_COEF: coef = data[CoefW-1:0];
        REG_GAIN_SHIFT: gain = data[GainW-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      int b;
      root = 0;
      for (b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    function void note_sample(logic signed [SampleW-1:0] smp, logic eob);
      longint x;
      longint p;
      longint nf;
      longint unsigned mag;
      longint unsigned scaled;
      bit [LevelW-1:0] lvl;
      samples++;
      x = longint'(smp) * (longint'(1) << FiltFrac);
      p = longint'(coef) * (x - filt);
      nf = filt + ((p + 32768) >>> 16);
      if (nf > FiltMax) nf = FiltMax;
      if (nf < FiltMin) nf = FiltMin;
      filt = nf;
      if (sq_count < MaxBufferSamples) begin
        mag = (nf < 0) ? -nf : nf;
        sq_sum += (mag * mag) >> SqShift;
        sq_count++;
      end
      if (eob) begin
        lvl = '0;
        if (sq_count != 0) begin
          scaled = root_floor((sq_sum / sq_count) << 1) << gain;
          lvl = (scaled > 65535) ? 16'hFFFF : scaled[LevelW-1:0];
        end
        if (lvl == 16'hFFFF) saturated++;
        levels_due.push_back(lvl);
        sq_sum = 0;
        sq_count = 0;
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_level(logic [LevelW-1:0] got);
      bit [LevelW-1:0] want;
      levels_seen++;
      if (levels_due.size() == 0) begin
        flag($sformatf("level %0d arrived with none outstanding", got));
        return;
      end
      want = levels_due.pop_front();
      if (got !== want) flag($sformatf("level expected %0d, got %0d", want, got));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SampleW-1:0] sample_i = '0;
  logic end_of_buffer_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [LevelW-1:0] level_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  level_scoreboard sb = new();
  bit hold_request = 1'b0;
  bit gaps_on = 1'b1;
  int burst_left = 0;
  int blocked_cycles = 0;
  int settings_written = 0;
  bit [CoefW-1:0] phase_coef [7] = '{16'hFFFF, 16'd1, 16'd3932, 16'h8000, 16'd0,
                                     16'h5A5A, 16'hA5A5};
  bit [GainW-1:0] phase_gain [7] = '{3'd0, 3'd4, 3'd2, 3'd3, 3'd5, 3'd6, 3'd1};

  lowpass_rms_level_meter_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .level_o        (level_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(sample_i, end_of_buffer_i);
      if (out_valid_o && out_ready_i) sb.check_level(level_o);
      if (in_valid_i && !in_ready_o) blocked_cycles++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("no item moved for %0d cycles", IdleLimit);
    $display("status: fail");
    $finish;
  end

  initial begin : receiver
    rx_mode_e mode;
    int span;
    int tick;
    mode = RX_ALWAYS;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(16, 160);
      end
      span--;
      tick++;
      case (mode)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 9) < 7);
        RX_SELDOM: out_ready_i <= ($urandom_range(0, 9) < 2);
        default: out_ready_i <= (tick % 5 == 0);
      endcase
    end
  end

  task automatic send_item(input logic signed [SampleW-1:0] smp, input logic eob);
    int gap;
    in_valid_i <= 1'b1;
    sample_i <= smp;
    end_of_buffer_i <= eob;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Lets every outstanding level arrive and the front part run dry.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.levels_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CoefW-1:0] coef, input logic [GainW-1:0] gain);
    logic [CfgDataW-1:0] gdata;
    gdata = CfgDataW'($urandom);
    gdata[GainW-1:0] = gain;
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_FILTER_COEF;
    cfg_data_i <= coef;
    sb.write_reg(REG_FILTER_COEF, coef);
    @(posedge clk_i);
    cfg_index_i <= REG_GAIN_SHIFT;
    cfg_data_i <= gdata;
    sb.write_reg(REG_GAIN_SHIFT, gdata);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_written++;
  endtask

  function automatic logic signed [SampleW-1:0] make_sample(smp_style_e style,
                                                           logic signed [SampleW-1:0] held);
    case (style)
      SMP_FULL: return SampleW'($urandom);
      SMP_QUIET: return SampleW'($urandom_range(0, 511) - 256);
      SMP_EXTREME: return $urandom_range(0, 1) ? SmpMax : SmpMin;
      default: return held;
    endcase
  endfunction

  task automatic run_buffers(input int n_items, input int max_len);
    int sent;
    int len;
    int cap;
    int r;
    int k;
    smp_style_e style;
    logic signed [SampleW-1:0] held;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      cap = (r < 6) ? 8 : (r < 9) ? 40 : 160;
      if (cap > max_len) cap = max_len;
      len = $urandom_range(1, cap);
      if (len > n_items - sent) len = n_items - sent;
      style = smp_style_e'($urandom_range(0, 3));
      held = SampleW'($urandom);
      for (k = 0; k < len; k++) send_item(make_sample(style, held), k == len - 1);
      sent += len;
    end
  endtask

  initial begin : stimulus
    int k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    repeat (2) send_item(SmpMax, 1'b0);
    send_item(SmpMax, 1'b1);
    repeat (2) send_item(SmpMin, 1'b0);
    send_item(SmpMin, 1'b1);
    send_item('0, 1'b1);
    send_item(SmpMax, 1'b0);
    send_item(SmpMin, 1'b0);
    send_item(SmpMax, 1'b0);
    send_item(SmpMin, 1'b1);
    send_item(16'sd1, 1'b0);
    send_item(-16'sd1, 1'b1);
    send_item(16'sh5555, 1'b0);
    send_item(16'shAAAA, 1'b1);
    settle();
    write_config(16'd0, 3'd7);
    send_item(16'sh1234, 1'b0);
    send_item(SmpMin, 1'b0);
    send_item(SmpMax, 1'b1);
    settle();
    write_config(16'hFFFF, 3'd0);
    send_item(SmpMax, 1'b0);
    send_item(SmpMin, 1'b1);
    send_item('0, 1'b1);

    for (k = 0; k < NumPhases; k++) begin
      settle();
      if (k < 7) write_config(phase_coef[k], phase_gain[k]);
      else write_config(CoefW'($urandom), GainW'($urandom));
      gaps_on = (k % 3 != 1);
      run_buffers(PhaseItems, 160);
      if (k == 4) begin
        hold_request = 1'b1;
        gaps_on = 1'b0;
        run_buffers(48, 2);
      end
    end
    settle();

    $display("covered %0d samples and %0d levels over %0d register settings",
             sb.samples, sb.levels_seen, settings_written);
    $display("%0d levels saturated; input held back for %0d cycles", sb.saturated,
             blocked_cycles);
    if (sb.errors > 0) $display("%0d mismatches in total", sb.errors);
    if (sb.levels_due.size() != 0) $display("%0d levels never arrived", sb.levels_due.size());
    if (sb.errors == 0 && sb.levels_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
